// ===== design/windowed_rms_peak_clip_meter_top_macros.svh =====
// Assertion macros used by the meter back end (wrm_back).
`ifndef WINDOWED_RMS_PEAK_CLIP_METER_TOP_MACROS_SVH
`define WINDOWED_RMS_PEAK_CLIP_METER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define WRM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define WRM_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define WRM_ASSERT(label, prop, msg)
`define WRM_IMPLY(label, ante, cons, msg)
`endif
`endif

// ===== design/wrm_pkg.sv =====
package wrm_pkg;

  localparam int CHANNELS     = 8;
  localparam int CH_W         = 3;
  localparam int MAX_WINDOW   = 4096;
  localparam int POS_W        = 12;
  localparam int WIN_W        = 13;
  localparam int SAMPLE_BITS  = 24;
  localparam int SQ_W         = 48;
  localparam int SUM_W        = 60;
  localparam int RING_DEPTH   = CHANNELS * MAX_WINDOW;
  localparam int SQRT_STEPS   = 30;
  localparam int CNT_W        = 6;
  localparam int FIFO_DEPTH   = 2;

  localparam logic [WIN_W-1:0]       WINDOW_RESET = WIN_W'(2400);
  localparam logic [WIN_W-1:0]       WINDOW_MAX   = WIN_W'(MAX_WINDOW);
  localparam logic [SAMPLE_BITS-1:0] UNITY        = SAMPLE_BITS'(1) << (SAMPLE_BITS - 3);
  localparam logic [SUM_W-1:0]       SQRT_BIT0    = SUM_W'(1) << (2 * (SQRT_STEPS - 1));

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic                          mode;
    logic [CH_W-1:0]               channel;
    logic signed [SAMPLE_BITS-1:0] sample;
  } wrm_in_t;

  typedef struct packed {
    logic [CH_W-1:0]        out_channel;
    logic [SAMPLE_BITS-1:0] peak_level;
    logic [SAMPLE_BITS-1:0] rms_level;
    logic                   clip_seen;
  } wrm_out_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic                   mode;
    logic [CH_W-1:0]        channel;
    logic [SAMPLE_BITS-1:0] mag;
  } wrm_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRD,
    S_PSUB,
    S_PADD,
    S_DIV,
    S_SQRT,
    S_OUT
  } wrm_state_t;

endpackage

// ===== design/wrm_front.sv =====
module wrm_front (
  input  wrm_pkg::wrm_in_t  in_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              q_full_i,
  output wrm_pkg::wrm_cmd_t cmd_o,
  output logic              cmd_push_o
);
  import wrm_pkg::*;

  logic [SAMPLE_BITS-1:0] raw;

  // Take an item whenever the queue has room.
  assign in_ready_o = !q_full_i;
  assign cmd_push_o = in_valid_i && !q_full_i;

  // Magnitude of the sample; the most negative value maps to 2^(N-1).
  assign raw = in_data_i.sample;
  always_comb begin
    cmd_o.mode    = in_data_i.mode;
    cmd_o.channel = in_data_i.channel;
    cmd_o.mag     = raw[SAMPLE_BITS-1] ? (~raw + SAMPLE_BITS'(1)) : raw;
  end

endmodule

// ===== design/wrm_fifo.sv =====
module wrm_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  wrm_pkg::wrm_cmd_t wr_data_i,
  input  logic              push_i,
  output logic              full_o,
  output wrm_pkg::wrm_cmd_t rd_data_o,
  output logic              valid_o,
  input  logic              pop_i
);
  import wrm_pkg::*;

  wrm_cmd_t   mem_r [0:FIFO_DEPTH-1];
  logic       wptr_r;
  logic       rptr_r;
  logic [1:0] count_r;

  assign full_o    = (count_r == 2'(FIFO_DEPTH));
  assign valid_o   = (count_r != 2'd0);
  assign rd_data_o = mem_r[rptr_r];

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= 1'b0;
      rptr_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push_i) wptr_r <= ~wptr_r;
      if (pop_i)  rptr_r <= ~rptr_r;
      count_r <= count_r + 2'(push_i) - 2'(pop_i);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_i) mem_r[wptr_r] <= wr_data_i;
  end

endmodule

// ===== design/wrm_back.sv =====
module wrm_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  wrm_pkg::wrm_cmd_t        cmd_i,
  input  logic                     cmd_valid_i,
  output logic                     cmd_pop_o,
  input  logic [wrm_pkg::WIN_W-1:0] win_i,
  input  logic                     clear_i,
  output wrm_pkg::wrm_out_t        out_data_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i
);
  import wrm_pkg::*;
  `include "windowed_rms_peak_clip_meter_top_macros.svh"

  wrm_state_t state_r, state_nxt;

  logic [CH_W-1:0]        ch_r;
  logic [SAMPLE_BITS-1:0] mag_r;
  logic [SQ_W-1:0]        sq_r;
  logic [SQ_W-1:0]        rdata_r;
  logic [SQ_W-1:0]        ring_mem [0:RING_DEPTH-1];

  logic [SUM_W-1:0]       sum_r  [0:CHANNELS-1];
  logic [WIN_W-1:0]       fill_r [0:CHANNELS-1];
  logic [POS_W-1:0]       pos_r  [0:CHANNELS-1];
  logic [SAMPLE_BITS-1:0] peak_r [0:CHANNELS-1];
  logic [CHANNELS-1:0]    clip_r;

  logic [WIN_W-1:0]       rem_r;
  logic [SUM_W-1:0]       quo_r;
  logic [SUM_W-1:0]       root_r;
  logic [SUM_W-1:0]       bit_r;
  logic [CNT_W-1:0]       cnt_r;

  logic                   out_valid_r;
  wrm_out_t               out_data_r;

  logic [POS_W-1:0]       pos_eff;
  logic [WIN_W-1:0]       pos_next;
  logic [CH_W+POS_W-1:0]  ring_addr;
  logic                   full;
  logic [WIN_W:0]         trial;
  logic                   trial_ge;
  logic [SUM_W-1:0]       root_try;
  logic                   out_load;

  // Ring slot of the current channel.
  assign pos_eff   = ({1'b0, pos_r[ch_r]} >= win_i) ? '0 : pos_r[ch_r];
  assign pos_next  = WIN_W'({1'b0, pos_eff}) + WIN_W'(1);
  assign ring_addr = {ch_r, pos_eff};
  assign full      = (fill_r[ch_r] >= win_i);

  // One quotient bit per cycle, one root bit pair per cycle.
  assign trial    = {rem_r, quo_r[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, fill_r[ch_r]});
  assign root_try = root_r + bit_r;

  assign out_load    = (state_r == S_OUT) && (!out_valid_r || out_ready_i);
  assign cmd_pop_o   = (state_r == S_IDLE) && cmd_valid_i;
  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid_i) begin
          if (cmd_i.mode == MODE_PUSH) begin
            state_nxt = S_PRD;
          end else if (fill_r[cmd_i.channel] == '0) begin
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_DIV;
          end
        end
      end
      S_PRD:  state_nxt = S_PSUB;
      S_PSUB: state_nxt = S_PADD;
      S_PADD: state_nxt = S_IDLE;
      S_DIV: begin
        if (cnt_r == CNT_W'(SUM_W - 1)) state_nxt = S_SQRT;
      end
      S_SQRT: begin
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Item datapath: square, divider and square root.
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        ch_r   <= cmd_i.channel;
        mag_r  <= cmd_i.mag;
        rem_r  <= '0;
        quo_r  <= sum_r[cmd_i.channel];
        root_r <= '0;
        bit_r  <= SQRT_BIT0;
        cnt_r  <= '0;
      end
      S_PRD: begin
        sq_r    <= SQ_W'(mag_r) * SQ_W'(mag_r);
        rdata_r <= ring_mem[ring_addr];
      end
      S_DIV: begin
        if (trial_ge) begin
          rem_r <= WIN_W'(trial - {1'b0, fill_r[ch_r]});
        end else begin
          rem_r <= trial[WIN_W-1:0];
        end
        quo_r <= {quo_r[SUM_W-2:0], trial_ge};
        cnt_r <= (cnt_r == CNT_W'(SUM_W - 1)) ? '0 : cnt_r + CNT_W'(1);
      end
      S_SQRT: begin
        if (quo_r >= root_try) begin
          quo_r  <= quo_r - root_try;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Ring of squares, one write and one registered read.
  always_ff @(posedge clk) begin
    if (state_r == S_PADD) ring_mem[ring_addr] <= sq_r;
  end

  // Per-channel meter state.
  always_ff @(posedge clk) begin
    if (!rst_n || clear_i) begin
      for (int i = 0; i < CHANNELS; i++) begin
        sum_r[i]  <= '0;
        fill_r[i] <= '0;
        pos_r[i]  <= '0;
        peak_r[i] <= '0;
      end
      clip_r <= '0;
    end else begin
      if (state_r == S_PSUB && full) begin
        sum_r[ch_r] <= sum_r[ch_r] - SUM_W'(rdata_r);
      end
      if (state_r == S_PADD) begin
        sum_r[ch_r] <= sum_r[ch_r] + SUM_W'(sq_r);
        if (!full) fill_r[ch_r] <= fill_r[ch_r] + WIN_W'(1);
        pos_r[ch_r] <= (pos_next >= win_i) ? '0 : pos_next[POS_W-1:0];
        if (mag_r > peak_r[ch_r]) peak_r[ch_r] <= mag_r;
        if (mag_r > UNITY) clip_r[ch_r] <= 1'b1;
      end
      if (out_load) begin
        peak_r[ch_r] <= '0;
        clip_r[ch_r] <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.out_channel <= ch_r;
      out_data_r.peak_level  <= peak_r[ch_r];
      out_data_r.rms_level   <= root_r[SAMPLE_BITS-1:0];
      out_data_r.clip_seen   <= clip_r[ch_r];
    end
  end

  // The fill count never passes the window, and the slot stays inside it.
  `WRM_IMPLY(a_fill_in_window, state_r != S_IDLE, fill_r[ch_r] <= win_i, "fill count above window")
  `WRM_IMPLY(a_pos_in_window, state_r == S_PADD, {1'b0, pos_eff} < win_i, "slot out of window")
  // A new item is dequeued only while the sequencer is free.
  `WRM_IMPLY(a_pop_idle, cmd_pop_o, state_r == S_IDLE && cmd_valid_i, "dequeue while busy")

endmodule

// ===== design/windowed_rms_peak_clip_meter_top.sv =====
// Push item: after dequeue, ring read, subtract, then add and write.
// Read item: divider, square root, then output load.
// A read of an empty window skips the divider and square root.
// A two-entry queue and an output register decouple the input and result sides.
// Synchronous active-low reset: meters cleared, window length 2400, no clearing pass.
module windowed_rms_peak_clip_meter_top (
  input  logic              clk,
  input  logic              rst_n,
  input  wrm_pkg::wrm_in_t  in_data,
  input  logic              in_valid,
  output logic              in_ready,
  output wrm_pkg::wrm_out_t out_data,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import wrm_pkg::*;

  logic [WIN_W-1:0] window_length_r;
  logic [WIN_W-1:0] win_eff;
  logic             cfg_wr;
  wrm_cmd_t         f_cmd;
  wrm_cmd_t         q_cmd;
  logic             q_push;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;

  // Configuration register at addresses 0 to 3; a write there also clears the channel meters.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == 1'b0);
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? 32'(window_length_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= WINDOW_RESET;
    end else if (cfg_wr) begin
      window_length_r <= cfg_pwdata[WIN_W-1:0];
    end
  end

  // Clamp the window into the supported range.
  assign win_eff = (window_length_r == '0)        ? WIN_W'(1) :
                   (window_length_r > WINDOW_MAX) ? WINDOW_MAX : window_length_r;

  wrm_front u_front (
    .in_data_i  (in_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .q_full_i   (q_full),
    .cmd_o      (f_cmd),
    .cmd_push_o (q_push)
  );

  wrm_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_data_i (f_cmd),
    .push_i    (q_push),
    .full_o    (q_full),
    .rd_data_o (q_cmd),
    .valid_o   (q_valid),
    .pop_i     (q_pop)
  );

  wrm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (q_cmd),
    .cmd_valid_i (q_valid),
    .cmd_pop_o   (q_pop),
    .win_i       (win_eff),
    .clear_i     (cfg_wr),
    .out_data_o  (out_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready)
  );

endmodule
